// File: rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REQ_W    = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  // Width that holds both a position and a count plus one without overflow.
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORT   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [COUNT_W-1:0]      count;
    logic                    list_empty;
  } ple_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_LAST,
    ST_DEL_FIRST,
    ST_DEL_SHIFT,
    ST_SORT_LOAD,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_DONE
  } ple_state_t;

endpackage

// File: rtl/core/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/positional_list_engine_core.sv
// Insert before position p shifts the entries from the tail down to that slot up by one
// and then writes the value; delete at p reads the entry out and shifts the ones above
// it down; sort is an insertion sort. Throughput: one item at a time; the list RAM (one
// read, one write per cycle) moves one entry per cycle while a shift runs.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; the
// list RAM itself is not cleared, since only entries below the count are ever read.
module positional_list_engine_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_data
);

  // Control state.
  ple_pkg::ple_state_t state_r, state_nxt;
  logic [ple_pkg::CNT_W-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;

  // Working registers. idx_r walks the entry being moved, i_r is the outer sort index,
  // tgt_r is the slot that receives the inserted value.
  logic [ple_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [ple_pkg::IDX_W-1:0] i_r, i_nxt;
  logic [ple_pkg::IDX_W-1:0] tgt_r, tgt_nxt;
  logic signed [ple_pkg::VAL_W-1:0] val_r, val_nxt;
  logic signed [ple_pkg::VAL_W-1:0] removed_r, removed_nxt;
  logic [ple_pkg::STAT_W-1:0] status_r, status_nxt;
  ple_pkg::ple_out_t out_data_r, out_data_nxt;

  // List RAM port.
  logic                       ram_we;
  logic [ple_pkg::IDX_W-1:0]  ram_waddr;
  logic [ple_pkg::VAL_W-1:0]  ram_wdata;
  logic [ple_pkg::IDX_W-1:0]  ram_raddr;
  logic [ple_pkg::VAL_W-1:0]  ram_rdata;

  // Request decode; the compares are widened so count+1 cannot wrap.
  logic [ple_pkg::CMP_W-1:0] pos_ext;
  logic [ple_pkg::CMP_W-1:0] cnt_ext;
  logic [ple_pkg::POS_W-1:0] pos_m1;
  logic [ple_pkg::IDX_W-1:0] pos_idx;
  logic [ple_pkg::IDX_W-1:0] last_idx;
  logic ins_ok, del_ok, is_full, is_append;
  logic rd_greater;

  assign pos_ext   = ple_pkg::CMP_W'(in_data.position);
  assign cnt_ext   = ple_pkg::CMP_W'(count_r);
  assign pos_m1    = in_data.position - ple_pkg::POS_W'(1);
  assign pos_idx   = ple_pkg::IDX_W'(pos_m1);
  assign last_idx  = ple_pkg::IDX_W'(count_r - ple_pkg::CNT_W'(1));
  assign ins_ok    = (in_data.position != '0) &&
                     (pos_ext <= cnt_ext + ple_pkg::CMP_W'(1));
  assign del_ok    = (in_data.position != '0) && (pos_ext <= cnt_ext);
  assign is_full   = (count_r == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign is_append = (pos_ext == cnt_ext + ple_pkg::CMP_W'(1));
  assign rd_greater = ($signed(ram_rdata) > val_r);

  ple_ram #(
    .WIDTH(ple_pkg::VAL_W),
    .DEPTH(ple_pkg::CAPACITY)
  ) u_list_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == ple_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    i_r        <= i_nxt;
    tgt_r      <= tgt_nxt;
    val_r      <= val_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Every move is a read of one entry followed, in the next cycle, by a write of the
  // returned data one slot over. The write of a step never hits the address read in
  // that same step, so the RAM needs no forwarding.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    tgt_nxt       = tgt_r;
    val_nxt       = val_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r;

    case (state_r)
      ple_pkg::ST_IDLE: begin
        if (in_valid) begin
          status_nxt  = ple_pkg::STAT_OK;
          removed_nxt = '0;
          state_nxt   = ple_pkg::ST_DONE;
          case (in_data.req_type)
            ple_pkg::REQ_INSERT: begin
              if (!ins_ok) begin
                status_nxt = ple_pkg::STAT_RANGE;
              end else if (is_full) begin
                status_nxt = ple_pkg::STAT_FULL;
              end else begin
                val_nxt = in_data.value;
                tgt_nxt = pos_idx;
                if (is_append) begin
                  state_nxt = ple_pkg::ST_INS_LAST;
                end else begin
                  // Shift from the tail down to the target slot.
                  ram_raddr = last_idx;
                  idx_nxt   = last_idx;
                  state_nxt = ple_pkg::ST_INS_SHIFT;
                end
              end
            end
            ple_pkg::REQ_DELETE: begin
              if (!del_ok) begin
                status_nxt = ple_pkg::STAT_RANGE;
              end else begin
                ram_raddr = pos_idx;
                idx_nxt   = pos_idx;
                state_nxt = ple_pkg::ST_DEL_FIRST;
              end
            end
            ple_pkg::REQ_SORT: begin
              // Insertion sort; lists of zero or one entry are already in order.
              if (count_r > ple_pkg::CNT_W'(1)) begin
                ram_raddr = ple_pkg::IDX_W'(1);
                i_nxt     = ple_pkg::IDX_W'(1);
                state_nxt = ple_pkg::ST_SORT_LOAD;
              end
            end
            default: begin
              status_nxt = ple_pkg::STAT_RANGE;
            end
          endcase
        end
      end

      ple_pkg::ST_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + ple_pkg::IDX_W'(1);
        ram_wdata = ram_rdata;
        if (idx_r == tgt_r) begin
          state_nxt = ple_pkg::ST_INS_LAST;
        end else begin
          idx_nxt   = idx_r - ple_pkg::IDX_W'(1);
          ram_raddr = idx_r - ple_pkg::IDX_W'(1);
        end
      end

      ple_pkg::ST_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = val_r;
        count_nxt = count_r + ple_pkg::CNT_W'(1);
        state_nxt = ple_pkg::ST_DONE;
      end

      ple_pkg::ST_DEL_FIRST: begin
        removed_nxt = ram_rdata;
        if (idx_r == last_idx) begin
          count_nxt = count_r - ple_pkg::CNT_W'(1);
          state_nxt = ple_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r + ple_pkg::IDX_W'(1);
          ram_raddr = idx_r + ple_pkg::IDX_W'(1);
          state_nxt = ple_pkg::ST_DEL_SHIFT;
        end
      end

      ple_pkg::ST_DEL_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - ple_pkg::IDX_W'(1);
        ram_wdata = ram_rdata;
        if (idx_r == last_idx) begin
          count_nxt = count_r - ple_pkg::CNT_W'(1);
          state_nxt = ple_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r + ple_pkg::IDX_W'(1);
          ram_raddr = idx_r + ple_pkg::IDX_W'(1);
        end
      end

      ple_pkg::ST_SORT_LOAD: begin
        // Hold the key and start scanning the sorted prefix from its top.
        val_nxt   = ram_rdata;
        idx_nxt   = i_r - ple_pkg::IDX_W'(1);
        ram_raddr = i_r - ple_pkg::IDX_W'(1);
        state_nxt = ple_pkg::ST_SORT_CMP;
      end

      ple_pkg::ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + ple_pkg::IDX_W'(1);
        if (rd_greater) begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = ple_pkg::ST_SORT_PLACE;
          end else begin
            idx_nxt   = idx_r - ple_pkg::IDX_W'(1);
            ram_raddr = idx_r - ple_pkg::IDX_W'(1);
          end
        end else begin
          ram_wdata = val_r;
          if (i_r == last_idx) begin
            state_nxt = ple_pkg::ST_DONE;
          end else begin
            i_nxt     = i_r + ple_pkg::IDX_W'(1);
            ram_raddr = i_r + ple_pkg::IDX_W'(1);
            state_nxt = ple_pkg::ST_SORT_LOAD;
          end
        end
      end

      ple_pkg::ST_SORT_PLACE: begin
        // The key is smaller than everything before it.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        if (i_r == last_idx) begin
          state_nxt = ple_pkg::ST_DONE;
        end else begin
          i_nxt     = i_r + ple_pkg::IDX_W'(1);
          ram_raddr = i_r + ple_pkg::IDX_W'(1);
          state_nxt = ple_pkg::ST_SORT_LOAD;
        end
      end

      ple_pkg::ST_DONE: begin
        // The output register parts the two sides; wait here only while an older
        // result is still unclaimed.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status        = status_r;
          out_data_nxt.removed_value = removed_r;
          out_data_nxt.count         = ple_pkg::COUNT_W'(count_r);
          out_data_nxt.list_empty    = (count_r == '0);
          out_valid_nxt              = 1'b1;
          state_nxt                  = ple_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ple_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::ST_IDLE || state_r == ple_pkg::ST_DONE) |-> !ram_we)
    else $error("list RAM written outside an operation");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == ple_pkg::ST_INS_SHIFT || state_r == ple_pkg::ST_DEL_SHIFT ||
                state_r == ple_pkg::ST_SORT_CMP)) |-> (ram_waddr != ram_raddr))
    else $error("shift step writes the entry it reads");

  a_removed_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ple_pkg::STAT_OK) |->
      (out_data_r.removed_value == '0))
    else $error("failed request reports a removed value");
`endif

endmodule
